/* rtl/ede_pkg.sv */
`timescale 1ns / 1ps

package ede_pkg;

    localparam int MAX_QUERY = 32;
    localparam int CODE_W    = 21;
    localparam int DIST_W    = 17;
    localparam int OUT_W     = 16;
    localparam int QIDX_W    = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int LEN_W     = $clog2(MAX_QUERY + 1);

    localparam logic [DIST_W-1:0] DIST_CAP = DIST_W'(1) << OUT_W;
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_QUERY);

    // One slot of the systolic chain. A query item carries the write position and the
    // new query length; a candidate item carries the left and diagonal values of the
    // row being computed.
    typedef struct packed {
        logic                   valid;
        logic                   is_query;
        logic                   last;
        logic                   trunc;
        logic [CODE_W-1:0]      code;
        logic                   wr_en;
        logic [QIDX_W-1:0]      wr_pos;
        logic [LEN_W-1:0]       len;
        logic [DIST_W-1:0]      left;
        logic [DIST_W-1:0]      diag;
    } ede_tok_t;

    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
        logic [DIST_W-1:0] r;
        r = (v >= DIST_CAP) ? DIST_CAP : v + DIST_W'(1);
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
                                               input logic [DIST_W-1:0] b);
        logic [DIST_W-1:0] r;
        r = (a < b) ? a : b;
        return r;
    endfunction

endpackage

/* rtl/ede_head.sv */
`timescale 1ns / 1ps

module ede_head
    import ede_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              s_valid,
    input  logic              s_kind,
    input  logic [CODE_W-1:0] s_char_code,
    input  logic              s_last,
    output ede_tok_t          tok_out
);

    logic [DIST_W-1:0] d0_reg, d0_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              open_reg, open_next;
    logic              trunc_reg, trunc_next;
    ede_tok_t          tok_reg, tok_next;

    logic [LEN_W-1:0]  base_len;
    logic              base_trunc;

    always_comb begin
        d0_next    = d0_reg;
        len_next   = len_reg;
        open_next  = open_reg;
        trunc_next = trunc_reg;
        base_len   = open_reg ? len_reg : '0;
        base_trunc = open_reg ? trunc_reg : 1'b0;

        tok_next          = '0;
        tok_next.valid    = s_valid;
        tok_next.is_query = ~s_kind;
        tok_next.last     = s_last;
        tok_next.code     = s_char_code;
        tok_next.trunc    = trunc_reg;
        tok_next.len      = len_reg;

        if (s_valid) begin
            if (!s_kind) begin
                if (base_len < LEN_MAX) begin
                    tok_next.wr_en  = 1'b1;
                    tok_next.wr_pos = base_len[QIDX_W-1:0];
                    len_next        = base_len + LEN_W'(1);
                    trunc_next      = base_trunc;
                end else begin
                    len_next   = base_len;
                    trunc_next = 1'b1;
                end
                open_next    = ~s_last;
                d0_next      = '0;
                tok_next.len = len_next;
            end else begin
                tok_next.diag = d0_reg;
                tok_next.left = sat_inc(d0_reg);
                d0_next       = s_last ? '0 : sat_inc(d0_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d0_reg        <= '0;
            len_reg       <= '0;
            open_reg      <= 1'b0;
            trunc_reg     <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            d0_reg    <= d0_next;
            len_reg   <= len_next;
            open_reg  <= open_next;
            trunc_reg <= trunc_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* rtl/ede_cell.sv */
`timescale 1ns / 1ps

module ede_cell
    import ede_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [QIDX_W-1:0] idx,
    input  ede_tok_t          tok_in,
    output ede_tok_t          tok_out
);

    logic [DIST_W-1:0] d_reg, d_next;
    logic [CODE_W-1:0] q_reg, q_next;
    logic              act_reg, act_next;
    ede_tok_t          tok_reg, tok_next;

    logic [DIST_W-1:0] d_rst;
    logic [DIST_W-1:0] v;
    logic              cost;

    always_comb begin
        d_rst    = DIST_W'(idx) + DIST_W'(1);
        d_next   = d_reg;
        q_next   = q_reg;
        act_next = act_reg;
        tok_next = tok_in;
        cost     = (q_reg != tok_in.code);
        v        = min2(min2(sat_inc(d_reg), sat_inc(tok_in.left)),
                        cost ? sat_inc(tok_in.diag) : tok_in.diag);

        if (tok_in.valid) begin
            if (tok_in.is_query) begin
                d_next   = d_rst;
                act_next = (LEN_W'(idx) < tok_in.len);
                if (tok_in.wr_en && (tok_in.wr_pos == idx)) begin
                    q_next = tok_in.code;
                end
            end else if (act_reg) begin
                tok_next.left = v;
                tok_next.diag = d_reg;
                d_next        = tok_in.last ? d_rst : v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else if (adv) begin
            d_reg   <= d_next;
            q_reg   <= q_next;
            act_reg <= act_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* rtl/edit_distance_engine_unit.sv */
`timescale 1ns / 1ps

// Levenshtein distance between a stored query and streamed candidate strings.
// The input channel (s_valid, s_ready) takes one character per item: s_kind 0 loads
// a query character, s_kind 1 streams a candidate character, s_last ends a string.
// Up to MAX_QUERY query characters are kept; further ones are dropped and reported
// through m_query_truncated. The result channel (m_valid, m_ready) gives one item for
// each candidate character with s_last set: the distance, saturated at 65535.
// The engine is a chain of MAX_QUERY cells, one per query position, behind a head
// stage that holds column zero. Every item travels down the chain one cell per cycle
// while the chain is not held, so one item is accepted each cycle while s_ready is
// high. A result passes the head, every cell and the output register. Query items
// travel the chain too, so they also follow each other and candidates back to back.
// Reset empties the chain and clears the query; a candidate then scores its length.
// When a result waits in the output register and another reaches the end of the
// chain, the whole chain holds and s_ready drops until m_ready takes the first one.
module edit_distance_engine_unit
    import ede_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_kind,
    input  logic [CODE_W-1:0] s_char_code,
    input  logic              s_last,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OUT_W-1:0]  m_distance,
    output logic              m_distance_saturated,
    output logic              m_query_truncated
);

    ede_tok_t         tok [MAX_QUERY+1];
    logic             adv;
    logic             tail_res;
    logic             m_valid_reg;
    logic [OUT_W-1:0] dist_reg;
    logic             sat_reg;
    logic             trunc_reg;

    assign tail_res = tok[MAX_QUERY].valid && !tok[MAX_QUERY].is_query
                      && tok[MAX_QUERY].last;
    assign adv      = !(tail_res && m_valid_reg && !m_ready);
    assign s_ready  = adv;

    ede_head u_head (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .adv         (adv),
        .s_valid     (s_valid),
        .s_kind      (s_kind),
        .s_char_code (s_char_code),
        .s_last      (s_last),
        .tok_out     (tok[0])
    );

    for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
        ede_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .idx     (QIDX_W'(i)),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (tail_res && adv) begin
                m_valid_reg <= 1'b1;
                sat_reg     <= tok[MAX_QUERY].left[OUT_W];
                dist_reg    <= tok[MAX_QUERY].left[OUT_W] ? '1
                                                          : tok[MAX_QUERY].left[OUT_W-1:0];
                trunc_reg   <= tok[MAX_QUERY].trunc;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_distance           = dist_reg;
    assign m_distance_saturated = sat_reg;
    assign m_query_truncated    = trunc_reg;

endmodule
